// ===== rtl/cppm_frame_generator_assert.svh =====
// ----------------------------------------------------------------------------
// CPPM frame generator assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CPPM_FRAME_GENERATOR_ASSERT_SVH
`define CPPM_FRAME_GENERATOR_ASSERT_SVH

// same-cycle implication
`define CPPM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CPPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cppm_pkg.sv =====
// ----------------------------------------------------------------------------
// CPPM package
// Register codes, reset values, request codes and the register set type.
// ----------------------------------------------------------------------------
package cppm_pkg;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int TIME_BITS_DEF    = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int CH_IDX_W   = 3;
	localparam int VALUE_W    = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_WIDTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_EDGE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_EDGE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_OFFSET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEVEL   = 3'd5;

	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [16:0] RST_FRAME_LENGTH = 17'd22000;
	localparam logic [15:0] RST_GAP_WIDTH    = 16'd400;
	localparam logic [15:0] RST_FIRST_EDGE   = 16'd400;
	localparam logic [15:0] RST_LAST_EDGE    = 16'd21999;
	localparam logic [15:0] RST_WIDTH_OFFSET = 16'hFE70;
	localparam logic        RST_IDLE_LEVEL   = 1'b1;

	typedef struct packed {
		logic [16:0] frame_length;
		logic [15:0] gap_width;
		logic [15:0] first_edge;
		logic [15:0] last_edge;
		logic [15:0] width_offset;
		logic        idle_level;
	} cfg_t;

endpackage

// ===== rtl/cppm_ram.sv =====
// ----------------------------------------------------------------------------
// CPPM generic RAM
// One write port, one read port with registered read data, no reset.
// ----------------------------------------------------------------------------
module cppm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/cppm_cfg.sv =====
// ----------------------------------------------------------------------------
// CPPM configuration registers
// Write-only register set decoded from the plain write port.
// ----------------------------------------------------------------------------
module cppm_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cppm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cppm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output cppm_pkg::cfg_t                     cfg
);
	import cppm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_length <= RST_FRAME_LENGTH;
			cfg_q.gap_width    <= RST_GAP_WIDTH;
			cfg_q.first_edge   <= RST_FIRST_EDGE;
			cfg_q.last_edge    <= RST_LAST_EDGE;
			cfg_q.width_offset <= RST_WIDTH_OFFSET;
			cfg_q.idle_level   <= RST_IDLE_LEVEL;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_LENGTH: cfg_q.frame_length <= cfg_data;
				CFG_GAP_WIDTH:    cfg_q.gap_width    <= cfg_data[15:0];
				CFG_FIRST_EDGE:   cfg_q.first_edge   <= cfg_data[15:0];
				CFG_LAST_EDGE:    cfg_q.last_edge    <= cfg_data[15:0];
				CFG_WIDTH_OFFSET: cfg_q.width_offset <= cfg_data[15:0];
				CFG_IDLE_LEVEL:   cfg_q.idle_level   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/cppm_frame_generator.sv =====
// ----------------------------------------------------------------------------
// CPPM frame generator: beats pass through stage 1, then the result register.
// Ticks run 1 beat per cycle unless results stall; a write (shadow copy) holds input.
// Reset clears control state, config to defaults; banks read zero via valid bits.
// ----------------------------------------------------------------------------
`include "cppm_frame_generator_assert.svh"

module cppm_frame_generator #(
	parameter int NUM_CHANNELS = cppm_pkg::NUM_CHANNELS_DEF,
	parameter int TIME_BITS    = cppm_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            req_type,
	input  logic [cppm_pkg::CH_IDX_W-1:0]   channel_index,
	input  logic [cppm_pkg::VALUE_W-1:0]    channel_value,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            ppm_out,
	output logic                            edge_now,
	output logic                            frame_start,
	input  logic                            cfg_we,
	input  logic [cppm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cppm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cppm_pkg::*;

	localparam int CHW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int NSLOT     = 1 << CHW;
	localparam int NUM_EDGES = 2 * NUM_CHANNELS + 2;
	localparam int EW        = $clog2(2 * NUM_CHANNELS + 3);
	localparam int CW        = (TIME_BITS + 1 > 17) ? TIME_BITS + 1 : 17;
	localparam int SW        = (TIME_BITS > 16) ? TIME_BITS : 16;

	cfg_t cfg;

	logic [TIME_BITS-1:0] tick_q, next_q;
	logic [EW-1:0]        eidx_q;
	logic                 lvl_q;
	logic [NSLOT-1:0]     saved_q, svld_q;

	logic                 valid_s1, write_s1;
	logic [CH_IDX_W-1:0]  idx_s1;
	logic [VALUE_W-1:0]   value_s1;

	logic result_valid_q, ppm_q, edge_q, fstart_q;

	logic [VALUE_W-1:0]   shadow_rd, frame_rd, fc, frame_wdata;
	logic [TIME_BITS-1:0] first_tb, last_tb, gap_tb, off_tb, next_e, next_f, tick_n;
	logic [SW-1:0]        off_sw;
	logic [EW-1:0]        eidx_e, eidx_f, half, eidx_d, e0, h0;
	logic [TIME_BITS-1:0] tick_d, next_d;
	logic [CHW-1:0]       chan, widx, rd_addr;
	logic [CW-1:0]        t1;
	logic                 frame_now, saved_eff, fire, wrap, lvl_d, frame_d;
	logic                 item_accept, s1_go, tick_go, wr_go, idx_ok, frame_we, idle_wr;

	cppm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign first_tb = TIME_BITS'(cfg.first_edge);
	assign last_tb  = TIME_BITS'(cfg.last_edge);
	assign gap_tb   = TIME_BITS'(cfg.gap_width);
	assign off_sw   = SW'(signed'(cfg.width_offset));
	assign off_tb   = off_sw[TIME_BITS-1:0];

	assign item_accept = item_valid && !item_stall;
	assign s1_go       = valid_s1 && (!result_valid_q || !result_stall);
	assign tick_go     = s1_go && (write_s1 == REQ_TICK);
	assign idx_ok      = 5'(idx_s1) < 5'(NUM_CHANNELS);
	assign wr_go       = s1_go && (write_s1 == REQ_WRITE) && idx_ok;
	assign widx        = CHW'(idx_s1);
	assign frame_we    = wr_go && !saved_q[widx];
	assign frame_wdata = svld_q[widx] ? shadow_rd : '0;
	assign idle_wr     = cfg_we && (cfg_index == CFG_IDLE_LEVEL);

	// hold new beats behind a channel write until its copy lands, or behind a stalled tick
	assign item_stall  = valid_s1 && !(s1_go && (write_s1 == REQ_TICK));

	always_comb begin
		frame_now = (tick_q == '0);
		eidx_e    = frame_now ? '0 : eidx_q;
		next_e    = frame_now ? first_tb : next_q;
		half      = eidx_e >> 1;
		chan      = half[CHW-1:0];
		saved_eff = !frame_now && saved_q[chan];
		if (saved_eff) begin
			fc = frame_rd;
		end else if (svld_q[chan]) begin
			fc = shadow_rd;
		end else begin
			fc = '0;
		end
		fire   = (eidx_e < EW'(NUM_EDGES)) && (tick_q == next_e);
		eidx_f = eidx_e + EW'(1);
		if (eidx_f == EW'(NUM_EDGES - 1)) begin
			next_f = last_tb;
		end else if (eidx_f[0]) begin
			next_f = next_e + TIME_BITS'(fc) + off_tb;
		end else if (eidx_f == EW'(NUM_EDGES)) begin
			next_f = next_e;
		end else begin
			next_f = next_e + gap_tb;
		end
		t1     = CW'(tick_q) + CW'(1);
		wrap   = (t1 >= CW'(cfg.frame_length)) || t1[TIME_BITS];
		tick_n = wrap ? '0 : t1[TIME_BITS-1:0];

		tick_d = tick_go ? tick_n : tick_q;
		eidx_d = tick_go ? (fire ? eidx_f : eidx_e) : eidx_q;
		next_d = tick_go ? (fire ? next_f : next_e) : next_q;
		lvl_d  = (tick_go && fire) ? !lvl_q : lvl_q;

		// fetch the written channel for a write, else the one a tick may need from the updated state
		frame_d = (tick_d == '0);
		e0      = frame_d ? '0 : eidx_d;
		h0      = e0 >> 1;
		rd_addr = (req_type == REQ_WRITE) ? CHW'(channel_index) : h0[CHW-1:0];
	end

	cppm_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (NUM_CHANNELS),
		.AW    (CHW)
	) u_shadow_ram (
		.clk   (clk),
		.we    (wr_go),
		.waddr (widx),
		.wdata (value_s1),
		.re    (item_accept),
		.raddr (rd_addr),
		.rdata (shadow_rd)
	);

	cppm_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (NUM_CHANNELS),
		.AW    (CHW)
	) u_frame_ram (
		.clk   (clk),
		.we    (frame_we),
		.waddr (widx),
		.wdata (frame_wdata),
		.re    (item_accept),
		.raddr (rd_addr),
		.rdata (frame_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			eidx_q  <= '0;
			next_q  <= TIME_BITS'(RST_FIRST_EDGE);
			lvl_q   <= RST_IDLE_LEVEL;
			saved_q <= '0;
			svld_q  <= '0;
		end else begin
			tick_q <= tick_d;
			eidx_q <= eidx_d;
			next_q <= next_d;
			if (idle_wr) begin
				lvl_q <= cfg_data[0];
			end else begin
				lvl_q <= lvl_d;
			end
			if (tick_go && frame_now) begin
				saved_q <= '0;
			end else if (wr_go) begin
				saved_q[widx] <= 1'b1;
				svld_q[widx]  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			write_s1 <= req_type;
			idx_s1   <= channel_index;
			value_s1 <= channel_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_go) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			ppm_q    <= lvl_d;
			edge_q   <= tick_go && fire;
			fstart_q <= tick_go && frame_now;
		end
	end

	assign result_valid = result_valid_q;
	assign ppm_out      = ppm_q;
	assign edge_now     = edge_q;
	assign frame_start  = fstart_q;

	`CPPM_ASSERT_NOW(a_eidx_range, 1'b1, eidx_q <= EW'(NUM_EDGES), "edge index past frame end")
	`CPPM_ASSERT_NOW(a_write_interlock, valid_s1 && write_s1, !item_accept, "beat taken behind write")
	`CPPM_ASSERT_NEXT(a_edge_toggle, tick_go && fire && !idle_wr, lvl_q != $past(lvl_q), "edge lost")
	`CPPM_ASSERT_NEXT(a_frame_count, tick_go && frame_now, tick_q <= TIME_BITS'(1), "bad restart")
	`CPPM_ASSERT_NEXT(a_frame_latch, tick_go && frame_now, saved_q == '0, "frame copy not reset")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CPPM frame generator testbench
// Streams tick and channel-write beats into the encoder under random sender
// bursts and receiver stalls, predicts every output sample (level, toggle and
// frame-start flags) with a local copy of the frame state, and compares each
// result beat in order. Frame settings are reprogrammed between phases, with
// short, zero, full and oversized frame lengths and extreme edge offsets.
// ----------------------------------------------------------------------------
module tb_top;
	import cppm_pkg::*;

	localparam int N_CHAN      = 8;
	localparam int N_EDGES     = 2 * N_CHAN + 2;
	localparam int QUIET_LIMIT = 2000;

	typedef struct {
		logic        kind;
		logic [2:0]  chan;
		logic [15:0] value;
	} ppm_req_t;

	typedef struct {
		logic level;
		logic toggled;
		logic frame_top;
	} ppm_sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic req_type = REQ_TICK;
	logic [CH_IDX_W-1:0] channel_index = '0;
	logic [VALUE_W-1:0] channel_value = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic ppm_out;
	logic edge_now;
	logic frame_start;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cppm_frame_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.req_type(req_type),
		.channel_index(channel_index),
		.channel_value(channel_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.ppm_out(ppm_out),
		.edge_now(edge_now),
		.frame_start(frame_start),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// frame encoder state
	cfg_t        frame_cfg;
	logic [15:0] frame_tick;
	int          edge_sel;
	logic [15:0] edge_at;
	logic [15:0] chan_shadow [N_CHAN];
	logic [15:0] frame_chan [N_CHAN];
	logic        level;

	ppm_req_t    req_backlog [$];
	ppm_sample_t sample_due_q [$];
	int          mismatches = 0;
	int          rx_beats = 0;
	logic        in_taken = 1'b0;
	int          quiet = 0;

	function automatic void load_register(logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_FRAME_LENGTH: frame_cfg.frame_length = data;
			CFG_GAP_WIDTH:    frame_cfg.gap_width = data[15:0];
			CFG_FIRST_EDGE:   frame_cfg.first_edge = data[15:0];
			CFG_LAST_EDGE:    frame_cfg.last_edge = data[15:0];
			CFG_WIDTH_OFFSET: frame_cfg.width_offset = data[15:0];
			CFG_IDLE_LEVEL: begin
				frame_cfg.idle_level = data[0];
				level = data[0];
			end
			default: ;
		endcase
	endfunction

	function automatic ppm_sample_t encode_beat(ppm_req_t r);
		ppm_sample_t s;
		logic [16:0] nxt;
		s.toggled = 1'b0;
		s.frame_top = 1'b0;
		if (r.kind == REQ_WRITE) begin
			chan_shadow[r.chan] = r.value;
		end else begin
			if (frame_tick == 16'd0) begin
				s.frame_top = 1'b1;
				frame_chan = chan_shadow;
				edge_sel = 0;
				edge_at = frame_cfg.first_edge;
			end
			if (edge_sel < N_EDGES && frame_tick == edge_at) begin
				level = ~level;
				s.toggled = 1'b1;
				edge_sel++;
				if (edge_sel == N_EDGES - 1)
					edge_at = frame_cfg.last_edge;
				else if (edge_sel < N_EDGES - 1 && edge_sel % 2 == 1)
					edge_at = edge_at + frame_chan[(edge_sel - 1) / 2] + frame_cfg.width_offset;
				else if (edge_sel < N_EDGES - 1)
					edge_at = edge_at + frame_cfg.gap_width;
			end
			nxt = {1'b0, frame_tick} + 17'd1;
			if (nxt >= frame_cfg.frame_length || nxt > 17'h0FFFF)
				nxt = '0;
			frame_tick = nxt[15:0];
		end
		s.level = level;
		return s;
	endfunction

	task automatic note_mismatch(input string msg);
		if (mismatches < 40)
			$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// monitor: register writes, result check, prediction of accepted beats
	always @(posedge clk or negedge arst_n) begin : monitor
		ppm_sample_t due;
		ppm_req_t    taken;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= item_valid && !item_stall;
			if (cfg_we)
				load_register(cfg_index, cfg_data);
			if (result_valid && !result_stall) begin
				rx_beats <= rx_beats + 1;
				if (sample_due_q.size() == 0) begin
					note_mismatch("result beat with nothing due");
				end else begin
					due = sample_due_q.pop_front();
					if (ppm_out !== due.level)
						note_mismatch($sformatf("ppm_out %b, want %b", ppm_out, due.level));
					if (edge_now !== due.toggled)
						note_mismatch($sformatf("edge_now %b, want %b", edge_now, due.toggled));
					if (frame_start !== due.frame_top)
						note_mismatch($sformatf("frame_start %b, want %b", frame_start,
							due.frame_top));
				end
			end
			if (item_valid && !item_stall) begin
				taken.kind = req_type;
				taken.chan = channel_index;
				taken.value = channel_value;
				sample_due_q.push_back(encode_beat(taken));
			end
		end
	end

	// sender: bursts of beats separated by random gaps
	always @(negedge clk) begin : sender
		ppm_req_t beat;
		int burst_left;
		int gap_left;
		if (arst_n && (!item_valid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				beat = req_backlog.pop_front();
				item_valid <= 1'b1;
				req_type <= beat.kind;
				channel_index <= beat.chan;
				channel_value <= beat.value;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver: stall modes, plus one long hold-off to back the block up
	always @(negedge clk) begin : receiver
		int hold_left;
		int mode;
		int mode_left;
		int phase_ctr;
		bit held_once;
		if (arst_n) begin
			phase_ctr++;
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (!held_once && rx_beats >= 150) begin
				held_once = 1'b1;
				hold_left = 150;
				result_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 3) == 0);
					2: result_stall <= ($urandom_range(0, 1) == 0);
					default: result_stall <= (phase_ctr % 5 >= 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet <= 0;
			end else if (quiet == QUIET_LIMIT) begin
				$display("cppm_frame_generator regression: fail");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	task automatic push_tick();
		ppm_req_t r;
		r.kind = REQ_TICK;
		r.chan = 3'($urandom_range(0, 7));
		r.value = 16'($urandom);
		req_backlog.push_back(r);
	endtask

	task automatic push_write(input logic [2:0] ch, input logic [15:0] val);
		ppm_req_t r;
		r.kind = REQ_WRITE;
		r.chan = ch;
		r.value = val;
		req_backlog.push_back(r);
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (req_backlog.size() != 0 || item_valid || sample_due_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	task automatic set_frame(input logic [16:0] flen, input logic [15:0] gap,
		input logic [15:0] first, input logic [15:0] last, input logic [15:0] offs,
		input logic idle);
		write_reg(CFG_FRAME_LENGTH, flen);
		write_reg(CFG_GAP_WIDTH, {1'b0, gap});
		write_reg(CFG_FIRST_EDGE, {1'b0, first});
		write_reg(CFG_LAST_EDGE, {1'b0, last});
		write_reg(CFG_WIDTH_OFFSET, {1'b0, offs});
		write_reg(CFG_IDLE_LEVEL, {16'd0, idle});
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		#1;
	endtask

	// well-formed frames: load all channels, then ticks with sparse writes
	task automatic queue_frames(input int n_items, input int vmax, input int full_pct);
		int i;
		for (i = 0; i < N_CHAN; i++)
			push_write(3'(i), ($urandom_range(0, 99) < full_pct) ? 16'($urandom)
				: 16'($urandom_range(0, vmax)));
		for (i = N_CHAN; i < n_items; i++) begin
			if ($urandom_range(0, 99) < 12)
				push_write(3'($urandom_range(0, 7)), ($urandom_range(0, 99) < full_pct)
					? 16'($urandom) : 16'($urandom_range(0, vmax)));
			else
				push_tick();
		end
	endtask

	initial begin : stimulus
		int p;
		int i;
		logic [16:0] flen;
		frame_cfg = '{RST_FRAME_LENGTH, RST_GAP_WIDTH, RST_FIRST_EDGE, RST_LAST_EDGE,
			RST_WIDTH_OFFSET, RST_IDLE_LEVEL};
		level = RST_IDLE_LEVEL;
		frame_tick = '0;
		edge_sel = 0;
		edge_at = RST_FIRST_EDGE;
		for (i = 0; i < N_CHAN; i++) begin
			chan_shadow[i] = '0;
			frame_chan[i] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		#1;

		// defaults: frame start on the first tick, channel extremes
		push_tick();
		push_write(3'd0, 16'd0);
		push_write(3'd7, 16'hFFFF);
		push_write(3'd3, 16'h5555);
		push_write(3'd4, 16'hAAAA);
		push_tick();
		push_tick();
		wait_drained();

		// edge at tick zero, zero gap makes a later edge fall in the past
		set_frame(17'd12, 16'd0, 16'd0, 16'd11, 16'd1, 1'b0);
		repeat (14) push_tick();
		wait_drained();

		for (p = 0; p < 13; p++) begin
			case (p)
				2: set_frame(17'd1, 16'd2, 16'd0, 16'd0, 16'd1, 1'b1);
				3: set_frame(17'd0, 16'd1, 16'd0, 16'd5, 16'd0, 1'b0);
				4: set_frame(17'd65536, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b1);
				5: set_frame(17'h1FFFF, 16'd0, 16'd3, 16'd40, 16'h7FFF, 1'b0);
				6: set_frame(17'd60, 16'd1, 16'd2, 16'd59, 16'h8000, 1'b1);
				default: begin
					flen = 17'($urandom_range(24, 72));
					set_frame(flen, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 6)),
						16'($urandom_range(flen / 2, flen)),
						16'($urandom_range(0, 6)) - 16'd2,
						1'($urandom_range(0, 1)));
				end
			endcase
			if (p == 6)
				queue_frames(110, 5, 60);
			else
				queue_frames((p == 0) ? 600 : 110, 5, 8);
			wait_drained();
		end

		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("cppm_frame_generator regression: pass");
		else
			$display("cppm_frame_generator regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cppm_pkg.sv
rtl/cppm_ram.sv
rtl/cppm_cfg.sv
rtl/cppm_frame_generator.sv
sim/tb_top.sv
